// ----- rtl/core/wwa_pkg.sv -----
`timescale 1ns / 1ps

package wwa_pkg;

  // Sizes of the weight store and the datapath.
  localparam int MAX_WEIGHTS      = 1024;
  localparam int SAMPLE_BITS      = 16;
  localparam int WEIGHT_FRAC_BITS = 14;
  localparam int WEIGHT_BITS      = 18;
  localparam int IDX_W            = $clog2(MAX_WEIGHTS);
  localparam int WS_W             = 11;
  localparam int FL_W             = 16;
  localparam int PROD_W           = SAMPLE_BITS + WEIGHT_BITS;

  // Input transfer layout of in_tdata, lowest field first.
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_WVAL_LSB  = IN_IDX_LSB + 10;
  localparam int IN_RE_LSB    = IN_WVAL_LSB + WEIGHT_BITS;
  localparam int IN_IM_LSB    = IN_RE_LSB + SAMPLE_BITS;
  localparam int IN_USED_W    = IN_IM_LSB + SAMPLE_BITS;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // Input kinds carried on in_tuser.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_WINDOW_SIZE  = 1'b0;
  localparam logic REG_FRAME_LENGTH = 1'b1;

  // Sample sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_RND
  } state_t;

  // Request to the index divider: weight index = pos * size_m1 / den.
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] size_m1;
    logic [IDX_W-1:0] den;
  } idx_req_t;

endpackage

// ----- rtl/core/wwa_ram.sv -----
`timescale 1ns / 1ps

module wwa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/wwa_index.sv -----
`timescale 1ns / 1ps

module wwa_index (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wwa_pkg::idx_req_t         req,
  output logic                      done,
  output logic [wwa_pkg::IDX_W-1:0] quot
);

  localparam int CNT_W = $clog2(wwa_pkg::IDX_W + 1);

  logic                        busy_r;
  logic                        mul_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [wwa_pkg::IDX_W-1:0]   pos_r;
  logic [wwa_pkg::IDX_W-1:0]   size_m1_r;
  logic [wwa_pkg::IDX_W-1:0]   den_r;
  logic [wwa_pkg::IDX_W-1:0]   rem_r;
  logic [wwa_pkg::IDX_W-1:0]   low_r;
  logic [wwa_pkg::IDX_W-1:0]   quot_r;
  logic [2*wwa_pkg::IDX_W-1:0] prod;
  logic [wwa_pkg::IDX_W:0]     trial;
  logic                        fits;

  // Numerator of the resampled index; the quotient is known to fit in
  // IDX_W bits, so the upper half of the product is already below den.
  assign prod  = pos_r * size_m1_r;
  assign trial = {rem_r, low_r[wwa_pkg::IDX_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = busy_r && !mul_r && (cnt_r == '0);
  assign quot  = quot_r;

  // Control: a multiply step, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      mul_r  <= 1'b1;
      cnt_r  <= CNT_W'(wwa_pkg::IDX_W);
    end else if (busy_r) begin
      if (mul_r) begin
        mul_r <= 1'b0;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // Restoring division datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      pos_r     <= req.pos;
      size_m1_r <= req.size_m1;
      den_r     <= req.den;
    end else if (mul_r) begin
      rem_r  <= prod[2*wwa_pkg::IDX_W-1:wwa_pkg::IDX_W];
      low_r  <= prod[wwa_pkg::IDX_W-1:0];
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= fits ? wwa_pkg::IDX_W'(trial - {1'b0, den_r})
                     : trial[wwa_pkg::IDX_W-1:0];
      low_r  <= {low_r[wwa_pkg::IDX_W-2:0], 1'b0};
      quot_r <= {quot_r[wwa_pkg::IDX_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/wwa_scale.sv -----
`timescale 1ns / 1ps

module wwa_scale (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic signed [wwa_pkg::SAMPLE_BITS-1:0] s_re,
  input  logic signed [wwa_pkg::SAMPLE_BITS-1:0] s_im,
  input  logic signed [wwa_pkg::WEIGHT_BITS-1:0] weight,
  output logic signed [wwa_pkg::SAMPLE_BITS-1:0] res_re,
  output logic signed [wwa_pkg::SAMPLE_BITS-1:0] res_im,
  output logic                                   clip
);

  localparam int RW = wwa_pkg::PROD_W - wwa_pkg::WEIGHT_FRAC_BITS;
  localparam int SB = wwa_pkg::SAMPLE_BITS;
  localparam logic signed [wwa_pkg::PROD_W-1:0] HALF =
    wwa_pkg::PROD_W'(1) <<< (wwa_pkg::WEIGHT_FRAC_BITS - 1);
  localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};

  logic signed [wwa_pkg::PROD_W-1:0] prod_re_r;
  logic signed [wwa_pkg::PROD_W-1:0] prod_im_r;
  logic signed [wwa_pkg::PROD_W-1:0] sum_re;
  logic signed [wwa_pkg::PROD_W-1:0] sum_im;
  logic signed [RW-1:0]              rnd_re;
  logic signed [RW-1:0]              rnd_im;
  logic                              ovf_re;
  logic                              ovf_im;

  // Both products are registered before rounding.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_re_r <= s_re * weight;
      prod_im_r <= s_im * weight;
    end
  end

  // Round half up, then drop the fraction bits (floor).
  assign sum_re = prod_re_r + HALF;
  assign sum_im = prod_im_r + HALF;
  assign rnd_re = sum_re[wwa_pkg::PROD_W-1:wwa_pkg::WEIGHT_FRAC_BITS];
  assign rnd_im = sum_im[wwa_pkg::PROD_W-1:wwa_pkg::WEIGHT_FRAC_BITS];

  // A part overflows when its upper bits are not all copies of the sign.
  assign ovf_re = (rnd_re[RW-1:SB-1] != '0) && (rnd_re[RW-1:SB-1] != '1);
  assign ovf_im = (rnd_im[RW-1:SB-1] != '0) && (rnd_im[RW-1:SB-1] != '1);

  assign res_re = ovf_re ? (rnd_re[RW-1] ? SAT_LO : SAT_HI) : rnd_re[SB-1:0];
  assign res_im = ovf_im ? (rnd_im[RW-1] ? SAT_LO : SAT_HI) : rnd_im[SB-1:0];
  assign clip   = ovf_re || ovf_im;

endmodule

// ----- rtl/core/window_weight_apply.sv -----
`timescale 1ns / 1ps

// Multiplies a stored window onto a sample stream, frame by frame. A transfer
// with in_tuser low writes one weight into the 1024-entry weight store; a
// transfer with in_tuser high windows one complex sample. When the window is
// longer than the frame (and the frame length is not 1), the resampled weight
// index floor(i*(size-1)/(frame-1)) comes from a restoring divider that
// produces one quotient bit per cycle, followed by a weight store read and a
// multiply step; otherwise no divider is used. A finished result waits in the
// output register while the next item is taken; a result that is still not
// taken when the next one is done holds that item back. The store has no
// reset, so every weight that a frame reaches must be written first. The user
// must write the configuration registers only while the block is idle; the
// block itself does not enforce this.

module window_weight_apply (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [wwa_pkg::FL_W-1:0]        cfg_wdata,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // weight_index[9:0], weight_value[27:10], sample_re[43:28], sample_im[59:44]
  input  logic [wwa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                            in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_re[15:0], out_im[31:16]
  output logic [wwa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // clipped[0]
  output logic                            out_tuser
);

  localparam int IW = wwa_pkg::IDX_W;
  localparam int FW = wwa_pkg::FL_W;
  localparam int SB = wwa_pkg::SAMPLE_BITS;

  wwa_pkg::state_t state_r;
  wwa_pkg::state_t state_nxt;

  logic [wwa_pkg::WS_W-1:0]        window_size_r;
  logic [FW-1:0]                   frame_length_r;
  logic [FW-1:0]                   pos_r;
  logic [FW-1:0]                   pos_nxt;
  logic signed [SB-1:0]            samp_re_r;
  logic signed [SB-1:0]            samp_im_r;
  logic                            last_r;
  logic                            out_valid_r;
  logic signed [SB-1:0]            out_re_r;
  logic signed [SB-1:0]            out_im_r;
  logic                            out_last_r;
  logic                            out_clip_r;

  logic                            in_xfer;
  logic                            out_xfer;
  logic                            sample_acc;
  logic                            write_acc;
  logic [wwa_pkg::WS_W-1:0]        size_c;
  logic [FW-1:0]                   n_c;
  logic [FW-1:0]                   n_m1;
  logic [FW-1:0]                   size_ext;
  logic [FW-1:0]                   size_m1_ext;
  logic [FW-1:0]                   pos_c;
  logic [FW-1:0]                   idx_full;
  logic                            last_c;
  logic                            div_mode;

  logic                            ram_re;
  logic [IW-1:0]                   ram_raddr;
  logic [wwa_pkg::WEIGHT_BITS-1:0] ram_rdata;
  wwa_pkg::idx_req_t               idx_req;
  logic                            idx_done;
  logic [IW-1:0]                   idx_quot;
  logic                            scale_load;
  logic                            out_load;
  logic signed [SB-1:0]            res_re;
  logic signed [SB-1:0]            res_im;
  logic                            res_clip;

  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_valid_r && out_tready;
  assign sample_acc = in_xfer && (in_tuser == wwa_pkg::ACT_SAMPLE);
  assign write_acc  = in_xfer && (in_tuser == wwa_pkg::ACT_WRITE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= wwa_pkg::WS_W'(1024);
      frame_length_r <= FW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wwa_pkg::REG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[wwa_pkg::WS_W-1:0];
        wwa_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Weight selection for the current frame position.
  always_comb begin
    if (window_size_r == '0) begin
      size_c = wwa_pkg::WS_W'(1);
    end else if (window_size_r > wwa_pkg::WS_W'(wwa_pkg::MAX_WEIGHTS)) begin
      size_c = wwa_pkg::WS_W'(wwa_pkg::MAX_WEIGHTS);
    end else begin
      size_c = window_size_r;
    end
    n_c         = (frame_length_r == '0) ? FW'(1) : frame_length_r;
    n_m1        = n_c - 1'b1;
    size_ext    = FW'(size_c);
    size_m1_ext = size_ext - 1'b1;
    last_c      = pos_r >= n_m1;
    pos_c       = last_c ? n_m1 : pos_r;
    div_mode    = 1'b0;
    if (size_ext == n_c) begin
      idx_full = pos_c;
    end else if (size_ext < n_c) begin
      idx_full = (pos_c < size_m1_ext) ? pos_c : size_m1_ext;
    end else if (n_c == FW'(1)) begin
      idx_full = '0;
    end else begin
      idx_full = '0;
      div_mode = 1'b1;
    end
    pos_nxt = last_c ? '0 : pos_c + 1'b1;
  end

  // Frame position and the sample held for the multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (sample_acc) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      samp_re_r <= in_tdata[wwa_pkg::IN_RE_LSB +: SB];
      samp_im_r <= in_tdata[wwa_pkg::IN_IM_LSB +: SB];
      last_r    <= last_c;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wwa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wwa_pkg::ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = div_mode ? wwa_pkg::ST_DIV : wwa_pkg::ST_MUL;
        end
      end
      wwa_pkg::ST_DIV: begin
        if (idx_done) begin
          state_nxt = wwa_pkg::ST_MUL;
        end
      end
      wwa_pkg::ST_MUL: state_nxt = wwa_pkg::ST_RND;
      wwa_pkg::ST_RND: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = wwa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wwa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_full[IW-1:0];
    scale_load = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      wwa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ram_re    = sample_acc && !div_mode;
      end
      wwa_pkg::ST_DIV: begin
        ram_re    = idx_done;
        ram_raddr = idx_quot;
      end
      wwa_pkg::ST_MUL: scale_load = 1'b1;
      wwa_pkg::ST_RND: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign idx_req.start   = sample_acc && div_mode;
  assign idx_req.pos     = pos_c[IW-1:0];
  assign idx_req.size_m1 = size_m1_ext[IW-1:0];
  assign idx_req.den     = n_m1[IW-1:0];

  wwa_index u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (idx_req),
    .done  (idx_done),
    .quot  (idx_quot)
  );

  wwa_ram #(
    .WIDTH (wwa_pkg::WEIGHT_BITS),
    .DEPTH (wwa_pkg::MAX_WEIGHTS)
  ) u_weights (
    .clk   (clk),
    .we    (write_acc),
    .waddr (in_tdata[wwa_pkg::IN_IDX_LSB +: IW]),
    .wdata (in_tdata[wwa_pkg::IN_WVAL_LSB +: wwa_pkg::WEIGHT_BITS]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wwa_scale u_scale (
    .clk    (clk),
    .load   (scale_load),
    .s_re   (samp_re_r),
    .s_im   (samp_im_r),
    .weight (ram_rdata),
    .res_re (res_re),
    .res_im (res_im),
    .clip   (res_clip)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r   <= res_re;
      out_im_r   <= res_im;
      out_last_r <= last_r;
      out_clip_r <= res_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = wwa_pkg::OUT_TDATA_W'({out_im_r, out_re_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_clip_r;

endmodule

// ----- tb/window_weight_apply_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both streams, keeps its own copy of the
// weight store, the registers and the frame position, and compares every
// result transfer with the oldest windowed sample still owed.
module window_weight_apply_checker import wwa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [FL_W-1:0]        cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // weight_index[9:0], weight_value[27:10], sample_re[43:28], sample_im[59:44]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // out_re[15:0], out_im[31:16]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  // clipped[0]
  input  logic                   out_tuser,
  output int                     error_count,
  output int                     results_owed
);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] re;
    logic [SAMPLE_BITS-1:0] im;
    logic                   frame_end;
    logic                   clipped;
  } windowed_t;

  logic [WEIGHT_BITS-1:0] weight_mem [MAX_WEIGHTS];
  logic [WS_W-1:0]        window_size;
  logic [FL_W-1:0]        frame_length;
  logic [FL_W-1:0]        frame_pos;
  windowed_t              owed_windowed [$];

  // Multiply by a weight, drop the fraction with rounding half up, saturate.
  function automatic logic [SAMPLE_BITS-1:0] round_scale(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic signed [WEIGHT_BITS-1:0] w,
    inout logic                          clip
  );
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    r = (longint'(s) * longint'(w) + (longint'(1) <<< (WEIGHT_FRAC_BITS - 1)))
        >>> WEIGHT_FRAC_BITS;
    if (r > hi) begin
      r = hi;
      clip = 1'b1;
    end
    if (r < lo) begin
      r = lo;
      clip = 1'b1;
    end
    return SAMPLE_BITS'(r);
  endfunction

  // Select the weight for the current position, window one sample and
  // advance the frame position.
  function automatic windowed_t window_sample(input logic [IN_TDATA_W-1:0] d);
    int unsigned size;
    int unsigned n;
    int unsigned pos;
    int unsigned slot;
    logic        last;
    logic        clip;
    windowed_t   r;
    size = window_size;
    if (size == 0) size = 1;
    if (size > MAX_WEIGHTS) size = MAX_WEIGHTS;
    n = frame_length;
    if (n == 0) n = 1;
    pos = frame_pos;
    // A position at or past the end of a shortened frame closes the frame.
    last = (pos >= n - 1);
    if (last) pos = n - 1;
    if (size == n) begin
      slot = pos;
    end else if (size < n) begin
      slot = (pos < size - 1) ? pos : size - 1;
    end else if (n == 1) begin
      slot = 0;
    end else begin
      slot = int'((longint'(pos) * longint'(size - 1)) / longint'(n - 1));
    end
    if (slot >= MAX_WEIGHTS) slot = MAX_WEIGHTS - 1;
    clip = 1'b0;
    r.re = round_scale(d[IN_RE_LSB +: SAMPLE_BITS], weight_mem[slot], clip);
    r.im = round_scale(d[IN_IM_LSB +: SAMPLE_BITS], weight_mem[slot], clip);
    r.frame_end = last;
    r.clipped = clip;
    frame_pos = last ? '0 : FL_W'(pos + 1);
    return r;
  endfunction

  // Register writes and input transfers first, then the result transfer.
  always @(posedge clk) begin
    windowed_t got;
    windowed_t want;
    if (!rst_n) begin
      error_count = 0;
      window_size = WS_W'(1024);
      frame_length = FL_W'(1024);
      frame_pos = '0;
      owed_windowed.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_SIZE) window_size = cfg_wdata[WS_W-1:0];
        else frame_length = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_WRITE) begin
          weight_mem[in_tdata[IN_IDX_LSB +: IDX_W]] = in_tdata[IN_WVAL_LSB +: WEIGHT_BITS];
        end else begin
          owed_windowed.push_back(window_sample(in_tdata));
        end
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0 +: SAMPLE_BITS], out_tdata[SAMPLE_BITS +: SAMPLE_BITS],
               out_tlast, out_tuser};
        if (owed_windowed.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: re=%0d im=%0d last=%0b clip=%0b",
                   $time, $signed(got.re), $signed(got.im), got.frame_end, got.clipped);
        end else begin
          want = owed_windowed.pop_front();
          if (got !== want) begin
            error_count++;
            $display({"%0t: expected re=%0d im=%0d last=%0b clip=%0b,",
                      " got re=%0d im=%0d last=%0b clip=%0b"},
                     $time, $signed(want.re), $signed(want.im), want.frame_end,
                     want.clipped, $signed(got.re), $signed(got.im), got.frame_end,
                     got.clipped);
          end
        end
      end
    end
    results_owed = owed_windowed.size();
  end

endmodule

// ----- tb/window_weight_apply_test.sv -----
`timescale 1ns / 1ps

module window_weight_apply_test;
  import wwa_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  // Weights written at the start; every window kept at or below this size
  // reaches only these entries.
  localparam int FILL_WEIGHTS  = 128;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = REG_WINDOW_SIZE;
  logic [FL_W-1:0]        cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // weight_index[9:0], weight_value[27:10], sample_re[43:28], sample_im[59:44]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // action[0]
  logic                   in_tuser = ACT_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_re[15:0], out_im[31:16]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  // clipped[0]
  logic                   out_tuser;

  int error_count;
  int results_owed;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  window_weight_apply uut (.*);

  window_weight_apply_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_BITS'($urandom_range(127) - 64);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(7))
      0:       return 18'h1FFFF;
      1:       return 18'h20000;
      2:       return 18'd16384;
      3:       return -18'sd16384;
      4:       return WEIGHT_BITS'($urandom_range(32768) - 16384);
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  // 0: no idling, 1: sender idle, 2: receiver stalling, 3: both.
  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 74 : (mode == 3) ? 33 : 0;
    recv_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 33 : 0;
  endtask

  // Offer one item, possibly after an idle gap, and wait for its transfer.
  task automatic send_item(input logic act, input logic [IDX_W-1:0] slot,
                           input logic [WEIGHT_BITS-1:0] wval,
                           input logic [SAMPLE_BITS-1:0] re,
                           input logic [SAMPLE_BITS-1:0] im);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= IN_TDATA_W'({im, re, wval, slot});
    do @(posedge clk); while (!in_tready);
  endtask

  // Fields that the item kind does not use carry random bits.
  task automatic send_weight(input int slot, input logic [WEIGHT_BITS-1:0] wval);
    send_item(ACT_WRITE, IDX_W'(slot), wval, SAMPLE_BITS'($urandom),
              SAMPLE_BITS'($urandom));
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] re,
                             input logic [SAMPLE_BITS-1:0] im);
    send_item(ACT_SAMPLE, IDX_W'($urandom), WEIGHT_BITS'($urandom), re, im);
  endtask

  // Stop offering, wait for every owed result, then let the block go quiet.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back; the spare high bits of the
  // window size word are random.
  task automatic configure(input int ws, input int fl);
    cfg_we <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_wdata <= {(FL_W - WS_W)'($urandom), WS_W'(ws)};
    @(posedge clk);
    cfg_index <= REG_FRAME_LENGTH;
    cfg_wdata <= FL_W'(fl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ws;
    int fl;
    int cap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A selected weight never lies past the effective window size, so the
    // lowest entries are written first and the windows stay within them.
    set_idling(0);
    for (int i = 0; i < FILL_WEIGHTS; i++) begin
      case (i)
        0:       send_weight(i, 18'h1FFFF);
        1:       send_weight(i, 18'h20000);
        2:       send_weight(i, 18'd0);
        3:       send_weight(i, 18'd16384);
        4:       send_weight(i, 18'd8192);
        5:       send_weight(i, -18'sd8192);
        default: send_weight(i, pick_weight());
      endcase
    end

    // Reset setting, window equal to frame: position i uses weight i.
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'd12345, 16'hFFFF);
    send_sample(16'h7FFF, 16'h8000);
    // Weights of plus and minus one half: exact halves round up.
    send_sample(16'd3, -16'sd3);
    send_sample(16'd3, -16'sd3);
    // A weight written just before the sample that uses it.
    send_weight(6, -18'sd16384);
    send_sample(16'h8000, 16'd100);
    finish_phase();

    // Zero window size and zero frame length both act as one.
    configure(0, 0);
    repeat (2) send_sample(pick_sample(), pick_sample());
    finish_phase();
    // Oversized window against a frame of one sample.
    configure(2047, 1);
    repeat (2) send_sample(pick_sample(), pick_sample());
    finish_phase();
    // Short window: the last weight is held to the frame end.
    configure(1, 5);
    repeat (5) send_sample(pick_sample(), pick_sample());
    finish_phase();
    // Longest frame, then shortened mid-frame so the position is past its end.
    configure(1024, 65535);
    repeat (3) send_sample(pick_sample(), pick_sample());
    finish_phase();
    configure(FILL_WEIGHTS, 3);
    repeat (3) send_sample(pick_sample(), pick_sample());
    finish_phase();
    configure(FILL_WEIGHTS, 2);
    repeat (2) send_sample(pick_sample(), pick_sample());
    finish_phase();

    // Random phases: mostly short frames so that frames close often.
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(9))
        0:       fl = 1;
        1:       fl = 65535;
        2:       fl = $urandom_range(65535);
        default: fl = $urandom_range(2, 40);
      endcase
      cap = (fl < FILL_WEIGHTS) ? fl : FILL_WEIGHTS;
      case ($urandom_range(5))
        0:       ws = cap;
        1:       ws = $urandom_range(1, cap);
        2:       ws = $urandom_range(cap, FILL_WEIGHTS);
        3:       ws = 0;
        4:       ws = (fl <= 1) ? 2047 : FILL_WEIGHTS;
        default: ws = $urandom_range(FILL_WEIGHTS);
      endcase
      configure(ws, fl);
      set_idling(ph % 4);
      // One phase holds the result side off while the sender keeps offering.
      if (ph == 6) begin
        set_idling(0);
        hold_requests++;
      end
      repeat (48) begin
        if ($urandom_range(4) == 0) begin
          send_weight($urandom_range(MAX_WEIGHTS - 1), pick_weight());
        end else begin
          send_sample(pick_sample(), ($urandom_range(7) == 0) ? '0 : pick_sample());
        end
      end
      finish_phase();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
